// ===== hw/rtl/mbb_pkg.sv =====
// shared types, codes and helpers of the monochrome bitmap blitter
package mbb_pkg;

  // width of a computed frame store byte address, before the range check
  localparam int unsigned MAW = 26;

  // signature bytes: 'B', 'M', 'd', 0
  localparam logic [7:0] SIG_0 = 8'h42;
  localparam logic [7:0] SIG_1 = 8'h4D;
  localparam logic [7:0] SIG_2 = 8'h64;
  localparam logic [7:0] SIG_3 = 8'h00;

  localparam logic [3:0] HDR_WIDTH_LO  = 4'd4;
  localparam logic [3:0] HDR_WIDTH_HI  = 4'd5;
  localparam logic [3:0] HDR_HEIGHT_LO = 4'd6;
  localparam logic [3:0] HDR_HEIGHT_HI = 4'd7;
  localparam logic [3:0] HDR_PAL_LO    = 4'd12;
  localparam logic [3:0] HDR_PAL_HI    = 4'd13;
  localparam logic [3:0] HDR_LAST      = 4'd15;

  typedef enum logic [1:0] {
    CMD_STREAM = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RES_READ     = 2'd0,
    RES_FINISHED = 2'd1,
    RES_REJECTED = 2'd2
  } res_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PALETTE = 2'd2,
    PH_PIXELS  = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_STREAM,
    S_RD0,
    S_WR0,
    S_RD1,
    S_WR1,
    S_CLEAR,
    S_READ,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_SWEEP,
    MEM_READ,
    MEM_RD0,
    MEM_WR0,
    MEM_RD1,
    MEM_WR1
  } mem_op_e;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    stream_step;
    logic    sweep_fmt;
    mem_op_e mem_op;
    logic    emit;
  } mbb_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e   in_cmd;
    phase_e phase;
    logic   res_now;
    logic   res_pend;
    logic   shift_nz;
    logic   sweep_last;
    logic   out_free;
  } mbb_stat_t;

  function automatic logic [7:0] flip_bits(input logic [7:0] v);
    logic [7:0] a;
    logic [7:0] b;
    a = ((v & 8'h55) << 1) | ((v & 8'hAA) >> 1);
    b = ((a & 8'h33) << 2) | ((a & 8'hCC) >> 2);
    return ((b & 8'h0F) << 4) | ((b & 8'hF0) >> 4);
  endfunction

  function automatic logic [7:0] sig_byte(input logic [1:0] k);
    logic [7:0] s;
    unique case (k)
      2'd0:    s = SIG_0;
      2'd1:    s = SIG_1;
      2'd2:    s = SIG_2;
      default: s = SIG_3;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/mbb_ctrl.sv =====
// operation sequencer of the bitmap blitter
module mbb_ctrl import mbb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  mbb_stat_t stat_i,
  output logic      in_ready_o,
  output mbb_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (stat_i.in_cmd)
            CMD_STREAM: state_d = S_STREAM;
            CMD_CLEAR:  state_d = S_CLEAR;
            CMD_READ:   state_d = S_READ;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_STREAM: begin
        if (stat_i.phase == PH_PIXELS) begin
          state_d = S_RD0;
        end else if (stat_i.res_now) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD0: state_d = S_WR0;
      S_WR0: begin
        if (stat_i.shift_nz) begin
          state_d = S_RD1;
        end else if (stat_i.res_pend) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD1: state_d = S_WR1;
      S_WR1: state_d = stat_i.res_pend ? S_EMIT : S_IDLE;
      S_CLEAR: begin
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_READ: state_d = S_EMIT;
      S_EMIT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '{capture: 1'b0, stream_step: 1'b0, sweep_fmt: 1'b0,
                   mem_op: MEM_NONE, emit: 1'b0};
    unique case (state_q)
      S_INIT:   cmd_o.mem_op = MEM_SWEEP;
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_STREAM: cmd_o.stream_step = 1'b1;
      S_RD0:    cmd_o.mem_op = MEM_RD0;
      S_WR0:    cmd_o.mem_op = MEM_WR0;
      S_RD1:    cmd_o.mem_op = MEM_RD1;
      S_WR1:    cmd_o.mem_op = MEM_WR1;
      S_CLEAR: begin
        cmd_o.mem_op    = MEM_SWEEP;
        cmd_o.sweep_fmt = 1'b1;
      end
      S_READ:   cmd_o.mem_op = MEM_READ;
      S_EMIT:   cmd_o.emit = 1'b1;
      default:  cmd_o.mem_op = MEM_NONE;
    endcase
  end

endmodule

// ===== hw/rtl/mbb_dp.sv =====
// image state, address arithmetic, frame store and result register of the blitter
module mbb_dp import mbb_pkg::*; #(
  parameter int unsigned LINES                = 128,
  parameter int unsigned PIXEL_BYTES_PER_LINE = 16,
  parameter int unsigned LINE_STRIDE          = 22
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mbb_cmd_t   cmd_i,
  output mbb_stat_t  stat_o,
  input  logic [2:0] in_user_i,
  input  logic [39:0] in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_user_o,
  output logic [7:0] out_data_o
);

  localparam int unsigned STORE_SIZE = LINES * LINE_STRIDE;
  localparam int unsigned AW = $clog2(STORE_SIZE);
  localparam int unsigned JW = $clog2(LINE_STRIDE);
  localparam logic [MAW-1:0] STORE_LIM = MAW'(STORE_SIZE);
  localparam logic [MAW-1:0] STORE_LIM1 = MAW'(STORE_SIZE - 1);
  localparam logic [AW-1:0]  CNT_LAST = AW'(STORE_SIZE - 1);
  localparam logic [JW-1:0]  J_LAST = JW'(LINE_STRIDE - 1);
  localparam logic [7:0]     STRIDE_W = 8'(LINE_STRIDE);
  localparam logic [7:0]     PB_W = 8'(PIXEL_BYTES_PER_LINE);
  localparam logic [7:0]     PB1_W = 8'(PIXEL_BYTES_PER_LINE + 1);

  // input fields
  cmd_e        in_cmd;
  logic        in_first;
  logic [7:0]  in_byte;
  logic [9:0]  in_dx;
  logic [9:0]  in_dy;
  logic [11:0] in_ra;

  assign in_cmd   = cmd_e'(in_user_i[1:0]);
  assign in_first = in_user_i[2];
  assign in_byte  = in_data_i[7:0];
  assign in_dx    = in_data_i[17:8];
  assign in_dy    = in_data_i[27:18];
  assign in_ra    = in_data_i[39:28];

  // captured item
  cmd_e        cmd_q;
  logic [7:0]  byte_q;
  logic [11:0] ra_q;
  logic        ra_ok_q;

  // image state
  phase_e      phase_q, phase_d;
  logic [3:0]  hcnt_q, hcnt_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [15:0] pal_q, pal_d;
  logic [17:0] skip_q, skip_d;
  logic [15:0] row_q, row_d;
  logic [12:0] col_q, col_d;
  logic [9:0]  ox_q, ox_d;
  logic [9:0]  oy_q, oy_d;
  logic        res_now;
  res_e        res_code;

  // pixel write operands
  logic [MAW-1:0] addr_q;
  logic [2:0]     l_q;
  logic [7:0]     lo_q;
  logic [7:0]     hi_q;

  // result
  logic        res_pend_q;
  res_e        res_code_q;
  logic        out_valid_q;
  logic [1:0]  out_user_q;
  logic [7:0]  out_data_q;
  logic        out_free;
  logic        emit_ok;

  // sweep counters
  logic [AW-1:0] cnt_q;
  logic [JW-1:0] j_q;
  logic [7:0]    n_q;
  logic          sweep_last;

  // memory
  logic [7:0]    frame_store_q [STORE_SIZE];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_idx;
  logic [7:0]    mem_wd;
  logic [7:0]    fmt_val;
  logic [7:0]    j8;

  // pixel arithmetic
  logic [16:0]    line_sum;
  logic [24:0]    line_base;
  logic [16:0]    cx;
  logic [MAW-1:0] addr_d;
  logic [7:0]     pix;
  logic [15:0]    pix_sh;
  logic [13:0]    wb;
  logic [13:0]    col_inc;
  logic [16:0]    row_inc;
  logic [MAW-1:0] addr1;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit_ok  = cmd_i.emit && out_free;

  always_comb begin
    line_sum  = 17'(oy_q) + 17'(row_q);
    line_base = 25'(line_sum) * 25'(STRIDE_W);
    cx        = 17'(ox_q) + 17'({col_q, 3'b000});
    addr_d    = MAW'(line_base) + MAW'(cx[16:3]);
    pix       = flip_bits(byte_q);
    pix_sh    = 16'(pix) << cx[2:0];
    wb        = 14'((17'(width_q) + 17'd7) >> 3);
    col_inc   = 14'(col_q) + 14'd1;
    row_inc   = 17'(row_q) + 17'd1;
  end

  // image state update
  always_comb begin
    phase_d  = phase_q;
    hcnt_d   = hcnt_q;
    width_d  = width_q;
    height_d = height_q;
    pal_d    = pal_q;
    skip_d   = skip_q;
    row_d    = row_q;
    col_d    = col_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    res_now  = 1'b0;
    res_code = RES_FINISHED;
    if (cmd_i.capture) begin
      if (in_cmd == CMD_STREAM && in_first) begin
        phase_d  = PH_HEADER;
        hcnt_d   = '0;
        width_d  = '0;
        height_d = '0;
        pal_d    = '0;
        skip_d   = '0;
        row_d    = '0;
        col_d    = '0;
        ox_d     = in_dx;
        oy_d     = in_dy;
      end
    end else if (cmd_i.stream_step) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (!hcnt_q[3] && !hcnt_q[2] && byte_q != sig_byte(hcnt_q[1:0])) begin
            phase_d  = PH_IDLE;
            res_now  = 1'b1;
            res_code = RES_REJECTED;
          end else begin
            if (hcnt_q == HDR_WIDTH_LO)  width_d[7:0]   = byte_q;
            if (hcnt_q == HDR_WIDTH_HI)  width_d[15:8]  = byte_q;
            if (hcnt_q == HDR_HEIGHT_LO) height_d[7:0]  = byte_q;
            if (hcnt_q == HDR_HEIGHT_HI) height_d[15:8] = byte_q;
            if (hcnt_q == HDR_PAL_LO)    pal_d[7:0]     = byte_q;
            if (hcnt_q == HDR_PAL_HI)    pal_d[15:8]    = byte_q;
            hcnt_d = hcnt_q + 4'd1;
            if (hcnt_q == HDR_LAST) begin
              skip_d = {pal_q, 2'b00};
              row_d  = '0;
              col_d  = '0;
              if (pal_q != '0) begin
                phase_d = PH_PALETTE;
              end else if (width_q == '0 || height_q == '0) begin
                phase_d = PH_IDLE;
                res_now = 1'b1;
              end else begin
                phase_d = PH_PIXELS;
              end
            end
          end
        end
        PH_PALETTE: begin
          skip_d = skip_q - 18'd1;
          if (skip_q == 18'd1) begin
            row_d = '0;
            col_d = '0;
            if (width_q == '0 || height_q == '0) begin
              phase_d = PH_IDLE;
              res_now = 1'b1;
            end else begin
              phase_d = PH_PIXELS;
            end
          end
        end
        PH_PIXELS: begin
          if (col_inc >= wb) begin
            col_d = '0;
            row_d = row_inc[15:0];
            if (row_inc >= 17'(height_q)) begin
              phase_d = PH_IDLE;
              res_now = 1'b1;
            end
          end else begin
            col_d = col_inc[12:0];
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      hcnt_q     <= '0;
      width_q    <= '0;
      height_q   <= '0;
      pal_q      <= '0;
      skip_q     <= '0;
      row_q      <= '0;
      col_q      <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      res_pend_q <= 1'b0;
      cnt_q      <= '0;
      j_q        <= '0;
      n_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      hcnt_q   <= hcnt_d;
      width_q  <= width_d;
      height_q <= height_d;
      pal_q    <= pal_d;
      skip_q   <= skip_d;
      row_q    <= row_d;
      col_q    <= col_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      if (cmd_i.stream_step) begin
        res_pend_q <= res_now;
      end else if (emit_ok) begin
        res_pend_q <= 1'b0;
      end
      if (cmd_i.mem_op == MEM_SWEEP) begin
        if (sweep_last) begin
          cnt_q <= '0;
          j_q   <= '0;
          n_q   <= '0;
        end else begin
          cnt_q <= cnt_q + AW'(1);
          if (j_q == J_LAST) begin
            j_q <= '0;
            n_q <= n_q + 8'd1;
          end else begin
            j_q <= j_q + JW'(1);
          end
        end
      end
      if (emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= in_cmd;
      byte_q  <= in_byte;
      ra_q    <= in_ra;
      ra_ok_q <= MAW'(in_ra) < STORE_LIM;
    end
    if (cmd_i.stream_step) begin
      addr_q     <= addr_d;
      l_q        <= cx[2:0];
      lo_q       <= pix_sh[7:0];
      hi_q       <= pix_sh[15:8];
      res_code_q <= res_code;
    end
    if (emit_ok) begin
      if (cmd_q == CMD_READ) begin
        out_user_q <= RES_READ;
        out_data_q <= ra_ok_q ? rdata_q : 8'h00;
      end else begin
        out_user_q <= res_code_q;
        out_data_q <= 8'h00;
      end
    end
  end

  // frame store port
  assign sweep_last = (cnt_q == CNT_LAST);
  assign j8         = 8'(j_q);
  assign addr1      = addr_q + MAW'(1);

  always_comb begin
    if (j8 < PB_W) begin
      fmt_val = 8'h00;
    end else if (j8 == PB1_W) begin
      fmt_val = n_q + 8'd2;
    end else begin
      fmt_val = 8'hff;
    end
  end

  always_comb begin
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    mem_idx = cnt_q;
    mem_wd  = 8'h00;
    unique case (cmd_i.mem_op)
      MEM_SWEEP: begin
        mem_we = 1'b1;
        mem_wd = cmd_i.sweep_fmt ? fmt_val : 8'h00;
      end
      MEM_READ: begin
        mem_re  = ra_ok_q;
        mem_idx = AW'(ra_q);
      end
      MEM_RD0: begin
        mem_re  = addr_q < STORE_LIM;
        mem_idx = AW'(addr_q);
      end
      MEM_WR0: begin
        mem_we  = addr_q < STORE_LIM;
        mem_idx = AW'(addr_q);
        mem_wd  = lo_q | (rdata_q & ~(8'hff << l_q));
      end
      MEM_RD1: begin
        mem_re  = addr_q < STORE_LIM1;
        mem_idx = AW'(addr1);
      end
      MEM_WR1: begin
        mem_we  = addr_q < STORE_LIM1;
        mem_idx = AW'(addr1);
        mem_wd  = hi_q | (rdata_q & (8'hff << l_q));
      end
      default: mem_idx = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_store_q[mem_idx] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= frame_store_q[mem_idx];
    end
  end

  assign stat_o = '{in_cmd: in_cmd, phase: phase_q, res_now: res_now,
                    res_pend: res_pend_q, shift_nz: (l_q != 3'd0),
                    sweep_last: sweep_last, out_free: out_free};

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_user_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/mono_bitmap_blit_framebuffer_core.sv =====
// top level of the 1-bpp bitmap blitter with its byte-wide frame store
//
// one command per slave transfer: tuser selects stream byte, clear or read
// and flags the first byte of an image; tdata carries the byte, the
// destination column and line, and the read address
// the master side returns one result per read, per finished image and per
// rejected image: tuser holds the status, tdata the byte read (else zero)
// commands are taken one at a time; the steps from one accept to the next:
//   header, palette or ignored byte: the stream step, then any result
//   pixel byte: the stream step, a read and a write of the first store byte,
//   a read and a write of the second when the column straddles two store
//   bytes, and the result on the last byte of an image
//   read: the store read, then the result; clear: a sweep of the whole store
// these steps come from the single store port: every pixel byte is a
// read then a write on each store byte it touches, clear writes one byte
// a cycle; after reset all LINES * LINE_STRIDE store bytes (2816 by
// default) are zeroed before the first command is taken
// a result waits in the output register while the receiver stalls; a new
// command is still taken, but a further result holds the block until the
// waiting one has gone
module mono_bitmap_blit_framebuffer_core import mbb_pkg::*; #(
  parameter int unsigned LINES                = 128,
  parameter int unsigned PIXEL_BYTES_PER_LINE = 16,
  parameter int unsigned LINE_STRIDE          = 22
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // data_byte, dest_x, dest_y, read_addr
  input  logic [2:0]  s_axis_tuser,  // cmd, first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // read_data
  output logic [1:0]  m_axis_tuser   // status
);

  mbb_cmd_t  cmd;
  mbb_stat_t stat;

  mbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  mbb_dp #(
    .LINES                (LINES),
    .PIXEL_BYTES_PER_LINE (PIXEL_BYTES_PER_LINE),
    .LINE_STRIDE          (LINE_STRIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_user_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule
